[design/cbs_pkg.sv]
package cbs_pkg;

  // stream geometry
  localparam int FRAME_WIDTH = 320;
  localparam int CENTRE      = FRAME_WIDTH / 2;

  // field widths
  localparam int CHAN_W   = 8;
  localparam int COL_W    = 9;
  localparam int COUNT_W  = 17;
  localparam int ERR_W    = 23;
  localparam int LIMIT_W  = 22;
  localparam int TARGET_W = 2;
  localparam int LEVEL_W  = 17;

  // signed column offset: must hold -CENTRE and the largest column minus CENTRE
  localparam int CENTRE_W = $clog2(CENTRE + 1);
  localparam int DIFF_W   = ((COL_W > CENTRE_W) ? COL_W : CENTRE_W) + 1;

  // config port
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 22;

  localparam logic [CFG_INDEX_W-1:0] CFG_TARGET = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ALPHA  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_MIN    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_FINISH = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_LIMIT  = 3'd4;

  // register reset values
  localparam logic [TARGET_W-1:0] TARGET_RST = 2'd0;
  localparam logic [CHAN_W-1:0]   ALPHA_RST  = 8'd25;
  localparam logic [LEVEL_W-1:0]  MIN_RST    = 17'd50;
  localparam logic [LEVEL_W-1:0]  FINISH_RST = 17'd55000;
  localparam logic [LIMIT_W-1:0]  LIMIT_RST  = 22'd5000;

  // target channel selector
  localparam logic [TARGET_W-1:0] TGT_RED   = 2'd0;
  localparam logic [TARGET_W-1:0] TGT_GREEN = 2'd1;
  localparam logic [TARGET_W-1:0] TGT_BLUE  = 2'd2;

  // saturation bounds
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [ERR_W-1:0]   ERR_MAX   = {1'b0, {(ERR_W-1){1'b1}}};
  localparam logic [ERR_W-1:0]   ERR_MIN   = {1'b1, {(ERR_W-1){1'b0}}};

  typedef enum logic [2:0] {
    STEER_SEARCH   = 3'd0,
    STEER_RIGHT    = 3'd1,
    STEER_LEFT     = 3'd2,
    STEER_STRAIGHT = 3'd3,
    STEER_REACHED  = 3'd4
  } steer_t;

endpackage

[design/colour_blob_steering.sv]
// Colour blob steering. Takes one RGBA pixel per transfer with its column and a
// frame_end flag, and sustains one pixel per clock while no frame_end pixel
// stalls. A pixel matches when alpha exceeds alpha_min and the selected
// target channel beats each other channel by more than 1.5x (exactly
// 2*target > 3*other); a target_colour of 3 matches nothing. Matches bump a
// saturating count and add (column - FRAME_WIDTH/2) to a saturating signed
// error. The frame_end pixel is judged first, then one result (count, error,
// steer code) is produced and both sums clear. Pipeline: input register, match
// register, accumulator/result register, output register; the output register
// lets pixels keep flowing while a result waits. Only a frame_end pixel can
// stall on an untaken result, holding later pixels. Config writes are always
// accepted (cfg_ready tied high) and must be made while no pixels are in flight.
module colour_blob_steering (
  input  logic                                clk,
  input  logic                                rst,
  // config write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [cbs_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [cbs_pkg::CFG_DATA_W-1:0]      cfg_data,
  // pixel channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [cbs_pkg::CHAN_W-1:0]          pix_red,
  input  logic [cbs_pkg::CHAN_W-1:0]          pix_green,
  input  logic [cbs_pkg::CHAN_W-1:0]          pix_blue,
  input  logic [cbs_pkg::CHAN_W-1:0]          pix_alpha,
  input  logic [cbs_pkg::COL_W-1:0]           pix_column,
  input  logic                                frame_end,
  // result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [cbs_pkg::COUNT_W-1:0]         match_count,
  output logic signed [cbs_pkg::ERR_W-1:0]    position_error,
  output logic [2:0]                          steer_code
);

  // ---------------------------------------------------------------------------
  // Config registers
  // ---------------------------------------------------------------------------
  logic [cbs_pkg::TARGET_W-1:0] target_colour;
  logic [cbs_pkg::CHAN_W-1:0]   alpha_min;
  logic [cbs_pkg::LEVEL_W-1:0]  min_level;
  logic [cbs_pkg::LEVEL_W-1:0]  finish_level;
  logic [cbs_pkg::LIMIT_W-1:0]  steer_limit;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_colour <= cbs_pkg::TARGET_RST;
      alpha_min     <= cbs_pkg::ALPHA_RST;
      min_level     <= cbs_pkg::MIN_RST;
      finish_level  <= cbs_pkg::FINISH_RST;
      steer_limit   <= cbs_pkg::LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      // unknown indexes are dropped
      unique case (cfg_index)
        cbs_pkg::CFG_TARGET: target_colour <= cfg_data[cbs_pkg::TARGET_W-1:0];
        cbs_pkg::CFG_ALPHA:  alpha_min     <= cfg_data[cbs_pkg::CHAN_W-1:0];
        cbs_pkg::CFG_MIN:    min_level     <= cfg_data[cbs_pkg::LEVEL_W-1:0];
        cbs_pkg::CFG_FINISH: finish_level  <= cfg_data[cbs_pkg::LEVEL_W-1:0];
        cbs_pkg::CFG_LIMIT:  steer_limit   <= cfg_data[cbs_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Flow control. Stage order: s1 (input) -> s2 (match) -> res -> out.
  // Non-last pixels are absorbed by the accumulator and never need res.
  // ---------------------------------------------------------------------------
  logic s1_valid, s2_valid, res_valid;
  logic s2_last;
  logic out_slot_ready, res_ready, s2_ready, s2_move, res_move;

  assign out_slot_ready = !out_valid || out_ready;
  assign res_move       = res_valid && out_slot_ready;
  assign res_ready      = !res_valid || res_move;
  assign s2_move        = s2_valid && (!s2_last || res_ready);
  assign s2_ready       = !s2_valid || s2_move;
  assign in_ready       = !s1_valid || s2_ready;

  // ---------------------------------------------------------------------------
  // Stage 1: input register
  // ---------------------------------------------------------------------------
  logic [cbs_pkg::CHAN_W-1:0] s1_red, s1_green, s1_blue, s1_alpha;
  logic [cbs_pkg::COL_W-1:0]  s1_column;
  logic                       s1_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_red    <= pix_red;
      s1_green  <= pix_green;
      s1_blue   <= pix_blue;
      s1_alpha  <= pix_alpha;
      s1_column <= pix_column;
      s1_last   <= frame_end;
    end
  end

  // ---------------------------------------------------------------------------
  // Match test and column offset
  // ---------------------------------------------------------------------------
  // 2*t > 3*o on 10-bit values
  function automatic logic dominates(input logic [cbs_pkg::CHAN_W-1:0] t,
                                     input logic [cbs_pkg::CHAN_W-1:0] o);
    logic [cbs_pkg::CHAN_W+1:0] t2, o3;
    t2 = {1'b0, t, 1'b0};
    o3 = {2'b00, o} + {1'b0, o, 1'b0};
    return t2 > o3;
  endfunction

  logic                              s1_match;
  logic signed [cbs_pkg::DIFF_W-1:0] s1_col_ext, s1_diff;

  always_comb begin
    s1_match = 1'b0;
    if (s1_alpha > alpha_min) begin
      unique case (target_colour)
        cbs_pkg::TGT_RED:   s1_match = dominates(s1_red,   s1_green) && dominates(s1_red,   s1_blue);
        cbs_pkg::TGT_GREEN: s1_match = dominates(s1_green, s1_red)   && dominates(s1_green, s1_blue);
        cbs_pkg::TGT_BLUE:  s1_match = dominates(s1_blue,  s1_red)   && dominates(s1_blue,  s1_green);
        default:            s1_match = 1'b0;   // unused selector
      endcase
    end
  end

  assign s1_col_ext = cbs_pkg::DIFF_W'({1'b0, s1_column});
  assign s1_diff    = s1_col_ext - cbs_pkg::DIFF_W'(cbs_pkg::CENTRE);

  // ---------------------------------------------------------------------------
  // Stage 2: match register
  // ---------------------------------------------------------------------------
  logic                              s2_match;
  logic signed [cbs_pkg::DIFF_W-1:0] s2_diff;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s2_ready) begin
      s2_match <= s1_match;
      s2_diff  <= s1_diff;
      s2_last  <= s1_last;
    end
  end

  // ---------------------------------------------------------------------------
  // Accumulators with saturation
  // ---------------------------------------------------------------------------
  logic [cbs_pkg::COUNT_W-1:0]      count_acc, count_acc_next;
  logic signed [cbs_pkg::ERR_W-1:0] error_acc, error_acc_next;
  logic signed [cbs_pkg::ERR_W:0]   err_sum;

  assign err_sum = (cbs_pkg::ERR_W+1)'(error_acc) + (cbs_pkg::ERR_W+1)'(s2_diff);

  always_comb begin
    count_acc_next = count_acc;
    error_acc_next = error_acc;
    if (s2_match) begin
      if (count_acc != cbs_pkg::COUNT_MAX) begin
        count_acc_next = count_acc + 1'b1;
      end
      // top two bits disagree: sum left the 23-bit range
      if (err_sum[cbs_pkg::ERR_W] != err_sum[cbs_pkg::ERR_W-1]) begin
        error_acc_next = err_sum[cbs_pkg::ERR_W] ? cbs_pkg::ERR_MIN : cbs_pkg::ERR_MAX;
      end else begin
        error_acc_next = err_sum[cbs_pkg::ERR_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count_acc <= '0;
      error_acc <= '0;
    end else if (s2_move) begin
      if (s2_last) begin
        count_acc <= '0;
        error_acc <= '0;
      end else begin
        count_acc <= count_acc_next;
        error_acc <= error_acc_next;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result register: frame totals
  // ---------------------------------------------------------------------------
  logic [cbs_pkg::COUNT_W-1:0]      res_count;
  logic signed [cbs_pkg::ERR_W-1:0] res_error;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_ready) begin
      res_valid <= s2_move && s2_last;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_move && s2_last) begin
      res_count <= count_acc_next;
      res_error <= error_acc_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Steering decision
  // ---------------------------------------------------------------------------
  logic signed [cbs_pkg::ERR_W:0] res_err_ext, lim_pos, lim_neg;
  cbs_pkg::steer_t                res_steer;

  assign res_err_ext = (cbs_pkg::ERR_W+1)'(res_error);
  assign lim_pos     = (cbs_pkg::ERR_W+1)'(steer_limit);
  assign lim_neg     = -lim_pos;

  always_comb begin
    priority if (res_count > finish_level) begin
      res_steer = cbs_pkg::STEER_REACHED;
    end else if (res_count <= min_level) begin
      res_steer = cbs_pkg::STEER_SEARCH;
    end else if (res_err_ext > lim_pos) begin
      res_steer = cbs_pkg::STEER_RIGHT;
    end else if (res_err_ext < lim_neg) begin
      res_steer = cbs_pkg::STEER_LEFT;
    end else begin
      res_steer = cbs_pkg::STEER_STRAIGHT;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_slot_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_move) begin
      match_count    <= res_count;
      position_error <= res_error;
      steer_code     <= res_steer;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // a frame_end pixel leaving s2 clears both sums
  a_clear_on_last: assert property (@(posedge clk) disable iff (rst)
    s2_move && s2_last |=> count_acc == '0 && error_acc == '0)
    else $error("accumulators not cleared after frame end");

  // a saturated count stays saturated within a frame
  a_count_sat: assert property (@(posedge clk) disable iff (rst)
    s2_move && !s2_last && count_acc == cbs_pkg::COUNT_MAX |=> count_acc == cbs_pkg::COUNT_MAX)
    else $error("match count wrapped");

  // a waiting result is not overwritten by the next frame
  a_res_held: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_move |=> res_valid && $stable(res_count) && $stable(res_error))
    else $error("pending result lost");

  // reached code only with a count above the finish level
  a_reached: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_steer == cbs_pkg::STEER_REACHED |-> res_count > finish_level)
    else $error("reached code without count above finish level");

endmodule
